@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl of the lru cache table
// no dependencies; simulation-only bodies, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent on the same edge
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// antecedent implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/lct_pkg.sv @@
// shared constants, codes and control struct of the lru cache table
// no dependencies; used by lct_entry and lru_cache_table_top
`default_nettype none

package lct_pkg;

  // default sizing
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 64;

  // fixed field widths
  localparam int ADDR_W    = 64;
  localparam int WORD_W    = 64;
  localparam int CAP_REG_W = 5;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // register index (word address bit)
  localparam logic REG_CAPACITY_IN_USE = 1'b0;

  // per-item update control broadcast to every entry
  typedef struct packed {
    logic promote;     // hit: make the matching entry most recent
    logic write_hit;   // insert hit: overwrite data of the matching entry
    logic insert_new;  // insert miss: age all entries, fill one free slot
    logic evict;       // insert miss on a full table: drop the oldest entry
  } lct_ctrl_t;

endpackage

`default_nettype wire

@@ src/lct_entry.sv @@
// one entry of the lru cache table: tag, data, valid bit and age rank
// depends on lct_pkg
`default_nettype none

module lct_entry #(
  parameter int DATA_WIDTH = lct_pkg::DATA_WIDTH_DEF,
  parameter int RANK_W     = 4
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire lct_pkg::lct_ctrl_t      ctrl,
  input  wire [lct_pkg::ADDR_W-1:0]    key,
  input  wire [DATA_WIDTH-1:0]         wdata,
  input  wire [RANK_W-1:0]             hit_rank,
  input  wire [RANK_W-1:0]             victim_rank,
  input  wire                          fill_sel,
  output logic                         valid,
  output logic                         match,
  output logic                         victim,
  output logic [RANK_W-1:0]            rank,
  output logic [lct_pkg::ADDR_W-1:0]   tag,
  output logic [DATA_WIDTH-1:0]        data
);

  // tag compare and oldest-entry detect
  assign match  = valid && (tag == key);
  assign victim = valid && (rank == victim_rank);

  // valid bit and age rank; promote and insert never come together
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else begin
      if (ctrl.promote) begin
        if (match) begin
          rank <= '0;
        end else if (valid && (rank < hit_rank)) begin
          rank <= rank + RANK_W'(1);
        end
      end else if (ctrl.insert_new) begin
        if (fill_sel) begin
          valid <= 1'b1;
          rank  <= '0;
        end else if (ctrl.evict && victim) begin
          valid <= 1'b0;
          rank  <= '0;
        end else if (valid) begin
          rank <= rank + RANK_W'(1);
        end
      end
    end
  end

  // tag and data storage
  always_ff @(posedge clk) begin
    if (ctrl.promote && ctrl.write_hit && match) begin
      data <= wdata;
    end
    if (ctrl.insert_new && fill_sel) begin
      tag  <= key;
      data <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ src/lru_cache_table_top.sv @@
// top level of the fully associative lru cache table
// depends on lct_pkg, lct_entry and assert_macros.svh
`default_nettype none

// Usage
//   Items enter on start while busy is low; busy never rises, so one item
//   may be accepted on every clock. operation selects lookup or insert,
//   address is the key (zero is rejected), write_data is stored on insert.
//   Each item yields one result, shown for one cycle with done high:
//   hit, read_data, evicted, evicted_address, rejected.
//   The item is registered at the accepting edge; the next edge compares
//   all entries in parallel, updates the tags, data and age ranks, and
//   registers the result; done is high in the cycle after that.
//   Throughput is one item per cycle, set by the parallel compare and
//   rank update across the entries.
//   Results cannot be held off by the receiver; each is accepted at the
//   edge that ends its done cycle.
//   The APB port holds capacity_in_use at byte address 0 (reset 16);
//   write it only while no item is in flight.
//   Reset empties the table at once: all valid bits and ranks clear.
module lru_cache_table_top #(
  parameter int CAPACITY   = lct_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = lct_pkg::DATA_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  // command channel
  input  wire                           start,
  output logic                          busy,
  input  wire                           operation,
  input  wire [lct_pkg::ADDR_W-1:0]     address,
  input  wire [lct_pkg::WORD_W-1:0]     write_data,
  // result channel
  output logic                          done,
  output logic                          hit,
  output logic [lct_pkg::WORD_W-1:0]    read_data,
  output logic                          evicted,
  output logic [lct_pkg::ADDR_W-1:0]    evicted_address,
  output logic                          rejected,
  // configuration port
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [lct_pkg::PADDR_W-1:0]    paddr,
  input  wire [lct_pkg::PDATA_W-1:0]    pwdata,
  output logic [lct_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int RANK_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // configuration register
  logic [lct_pkg::CAP_REG_W-1:0] capacity_in_use;

  // input register
  logic                        in_valid;
  logic                        in_op;
  logic [lct_pkg::ADDR_W-1:0]  in_addr;
  logic [DATA_WIDTH-1:0]       in_wdata;

  // table state and lane outputs
  logic [CNT_W-1:0]            occ;
  logic [CNT_W-1:0]            occ_next;
  logic [CAPACITY-1:0]         valid_vec;
  logic [CAPACITY-1:0]         match_vec;
  logic [CAPACITY-1:0]         victim_vec;
  logic [CAPACITY-1:0]         free_vec;
  logic [CAPACITY-1:0]         fill_vec;
  logic [RANK_W-1:0]           rank [CAPACITY];
  logic [lct_pkg::ADDR_W-1:0]  tag [CAPACITY];
  logic [DATA_WIDTH-1:0]       data [CAPACITY];

  // per-item decode
  lct_pkg::lct_ctrl_t          ctrl;
  logic                        addr_zero;
  logic                        item;
  logic                        hit_any;
  logic                        full;
  logic [CNT_W-1:0]            limit;
  logic [RANK_W-1:0]           hit_rank;
  logic [RANK_W-1:0]           victim_rank;
  logic [DATA_WIDTH-1:0]       hit_data;
  logic [lct_pkg::ADDR_W-1:0]  victim_addr;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // configuration write and read back
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= lct_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == lct_pkg::REG_CAPACITY_IN_USE)) begin
      capacity_in_use <= pwdata[lct_pkg::CAP_REG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lct_pkg::REG_CAPACITY_IN_USE) begin
      prdata = lct_pkg::PDATA_W'(capacity_in_use);
    end
  end

  // effective limit: zero acts as one, above capacity acts as capacity
  always_comb begin
    priority if (capacity_in_use == '0) begin
      limit = CNT_W'(1);
    end else if (32'(capacity_in_use) > 32'(CAPACITY)) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = CNT_W'(capacity_in_use);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op    <= operation;
      in_addr  <= address;
      in_wdata <= DATA_WIDTH'(write_data);
    end
  end

  // gather hit data, hit rank and victim tag over the lanes
  always_comb begin
    hit_data    = '0;
    hit_rank    = '0;
    victim_addr = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_data    = hit_data | (match_vec[i] ? data[i] : '0);
      hit_rank    = hit_rank | (match_vec[i] ? rank[i] : '0);
      victim_addr = victim_addr | (victim_vec[i] ? tag[i] : '0);
    end
  end

  // item decode
  assign addr_zero   = (in_addr == '0);
  assign item        = in_valid && !addr_zero;
  assign hit_any     = |match_vec;
  assign full        = (occ >= limit) && (occ != '0);
  assign victim_rank = RANK_W'(occ - CNT_W'(1));

  always_comb begin
    ctrl.promote    = item && hit_any;
    ctrl.write_hit  = (in_op == lct_pkg::OP_INSERT);
    ctrl.insert_new = item && (in_op == lct_pkg::OP_INSERT) && !hit_any;
    ctrl.evict      = ctrl.insert_new && full;
  end

  // lowest free slot after the eviction
  assign free_vec = ~valid_vec | (ctrl.evict ? victim_vec : '0);
  assign fill_vec = free_vec & (~free_vec + CAPACITY'(1));

  // entry lanes
  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    lct_entry #(
      .DATA_WIDTH (DATA_WIDTH),
      .RANK_W     (RANK_W)
    ) u_entry (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .key         (in_addr),
      .wdata       (in_wdata),
      .hit_rank    (hit_rank),
      .victim_rank (victim_rank),
      .fill_sel    (fill_vec[i]),
      .valid       (valid_vec[i]),
      .match       (match_vec[i]),
      .victim      (victim_vec[i]),
      .rank        (rank[i]),
      .tag         (tag[i]),
      .data        (data[i])
    );
  end

  // occupancy count
  always_comb begin
    occ_next = occ;
    if (ctrl.insert_new && !ctrl.evict) begin
      occ_next = occ + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    hit             <= item && hit_any;
    read_data       <= (item && hit_any && (in_op == lct_pkg::OP_LOOKUP))
                       ? lct_pkg::WORD_W'(hit_data) : '0;
    evicted         <= ctrl.evict;
    evicted_address <= ctrl.evict ? victim_addr : '0;
    rejected        <= in_valid && addr_zero;
  end

  // checks
  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_occ_matches_valid, clk, rst, $countones(valid_vec) == int'(occ))
  `ASSERT_ALWAYS(a_occ_in_range, clk, rst, int'(occ) <= CAPACITY)
  `ASSERT_IMPLY(a_single_victim, clk, rst, ctrl.evict, $onehot(victim_vec))
  `ASSERT_IMPLY(a_single_match, clk, rst, in_valid, $onehot0(match_vec))
  `ASSERT_IMPLY(a_reject_alone, clk, rst, done && rejected, !hit && !evicted)
  `ASSERT_NEXT(a_done_follows_item, clk, rst, in_valid, done)

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// self-checking bench for lru_cache_table_top: a directed table, then random phases
// each at its own capacity setting; checks every result against a typed result
// or an in-bench lru model; depends on lct_pkg and the rtl of lru_cache_table_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_WAYS        = lct_pkg::CAPACITY_DEF;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int RAND_CAP_PHASE  = 6;
  localparam int NUM_DIRECTED    = 22;
  localparam logic [lct_pkg::PADDR_W-1:0] CAP_REG_ADDR =
    {lct_pkg::REG_CAPACITY_IN_USE, 2'b00};
  localparam logic [63:0] ONES = '1;

  typedef struct packed {
    logic                       hit;
    logic [lct_pkg::WORD_W-1:0] read_data;
    logic                       evicted;
    logic [lct_pkg::ADDR_W-1:0] evicted_address;
    logic                       rejected;
  } cache_result_t;

  localparam cache_result_t NO_RESULT = '0;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one line of the directed table; a config row carries its value in wdata
  typedef struct {
    row_kind_t                  kind;
    logic                       op;
    logic [lct_pkg::ADDR_W-1:0] addr;
    logic [lct_pkg::WORD_W-1:0] wdata;
    bit                         typed;
    cache_result_t              result;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         operation = 1'b0;
  logic [lct_pkg::ADDR_W-1:0]   address = '0;
  logic [lct_pkg::WORD_W-1:0]   write_data = '0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [lct_pkg::PADDR_W-1:0]  paddr = '0;
  logic [lct_pkg::PDATA_W-1:0]  pwdata = '0;
  logic                         busy;
  logic                         done;
  logic                         hit;
  logic [lct_pkg::WORD_W-1:0]   read_data;
  logic                         evicted;
  logic [lct_pkg::ADDR_W-1:0]   evicted_address;
  logic                         rejected;
  logic [lct_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  lru_cache_table_top u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .address         (address),
    .write_data      (write_data),
    .done            (done),
    .hit             (hit),
    .read_data       (read_data),
    .evicted         (evicted),
    .evicted_address (evicted_address),
    .rejected        (rejected),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lru table model state
  logic                          tag_valid [NUM_WAYS];
  logic [lct_pkg::ADDR_W-1:0]    tag_addr  [NUM_WAYS];
  logic [lct_pkg::WORD_W-1:0]    tag_data  [NUM_WAYS];
  int                            age_rank  [NUM_WAYS];
  int                            fill_count;
  logic [lct_pkg::CAP_REG_W-1:0] cap_setting;

  cache_result_t pending_results [$];
  int error_count  = 0;
  int items_sent   = 0;
  int hit_count    = 0;
  int evict_count  = 0;
  int reject_count = 0;

  // directed table: refusals, extremes, in-place update, capacity edge values
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // zero address is refused on both operations
    '{ROW_ITEM, lct_pkg::OP_LOOKUP, 64'h0, 64'h0, 1'b1,
      '{1'b0, 64'h0, 1'b0, 64'h0, 1'b1}},
    '{ROW_ITEM, lct_pkg::OP_INSERT, 64'h0, ONES, 1'b1,
      '{1'b0, 64'h0, 1'b0, 64'h0, 1'b1}},
    // miss on an empty table, then fill and read back the extremes
    '{ROW_ITEM, lct_pkg::OP_LOOKUP, ONES, ONES, 1'b1, NO_RESULT},
    '{ROW_ITEM, lct_pkg::OP_INSERT, ONES, ONES, 1'b1, NO_RESULT},
    '{ROW_ITEM, lct_pkg::OP_LOOKUP, ONES, 64'h0, 1'b1,
      '{1'b1, ONES, 1'b0, 64'h0, 1'b0}},
    '{ROW_ITEM, lct_pkg::OP_INSERT, 64'h1, 64'h0, 1'b1, NO_RESULT},
    // insert of a present address overwrites in place
    '{ROW_ITEM, lct_pkg::OP_INSERT, ONES, 64'h5555_5555_5555_5555, 1'b1,
      '{1'b1, 64'h0, 1'b0, 64'h0, 1'b0}},
    '{ROW_ITEM, lct_pkg::OP_LOOKUP, ONES, 64'h0, 1'b1,
      '{1'b1, 64'h5555_5555_5555_5555, 1'b0, 64'h0, 1'b0}},
    '{ROW_ITEM, lct_pkg::OP_LOOKUP, 64'h1, ONES, 1'b1,
      '{1'b1, 64'h0, 1'b0, 64'h0, 1'b0}},
    // capacity zero acts as one while two entries are held
    '{ROW_CFG, lct_pkg::OP_LOOKUP, 64'h0, 64'h0, 1'b0, NO_RESULT},
    '{ROW_ITEM, lct_pkg::OP_INSERT, 64'h2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
      '{1'b0, 64'h0, 1'b1, ONES, 1'b0}},
    '{ROW_ITEM, lct_pkg::OP_INSERT, 64'h3, 64'h3, 1'b1,
      '{1'b0, 64'h0, 1'b1, 64'h1, 1'b0}},
    '{ROW_ITEM, lct_pkg::OP_LOOKUP, 64'h2, 64'h0, 1'b1,
      '{1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0, 1'b0}},
    '{ROW_ITEM, lct_pkg::OP_INSERT, 64'h4, 64'h4, 1'b1,
      '{1'b0, 64'h0, 1'b1, 64'h3, 1'b0}},
    // upper write bits dropped: 17 acts as the full table
    '{ROW_CFG, lct_pkg::OP_LOOKUP, 64'h0, 64'hFFFF_FFF1, 1'b0, NO_RESULT},
    '{ROW_ITEM, lct_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
      1'b1, NO_RESULT},
    '{ROW_ITEM, lct_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, ONES, 1'b1,
      '{1'b1, 64'h8000_0000_0000_0000, 1'b0, 64'h0, 1'b0}},
    // two entries allowed with three held
    '{ROW_CFG, lct_pkg::OP_LOOKUP, 64'h0, 64'h2, 1'b0, NO_RESULT},
    '{ROW_ITEM, lct_pkg::OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0,
      1'b0, NO_RESULT},
    '{ROW_ITEM, lct_pkg::OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, ONES, 1'b0, NO_RESULT},
    '{ROW_ITEM, lct_pkg::OP_LOOKUP, 64'h4, 64'h0, 1'b0, NO_RESULT},
    '{ROW_ITEM, lct_pkg::OP_LOOKUP, 64'h2, 64'h0, 1'b0, NO_RESULT}
  };

  logic [lct_pkg::PDATA_W-1:0] phase_caps [RAND_PHASES] = '{
    32'd16, 32'd1, 32'd2, 32'd31, 32'd0, 32'd5, 32'd0, 32'd16
  };

  // capacity in effect after clamping to 1..NUM_WAYS
  function automatic int cap_limit(logic [lct_pkg::CAP_REG_W-1:0] cap);
    int lim;
    lim = cap;
    if (lim < 1) lim = 1;
    if (lim > NUM_WAYS) lim = NUM_WAYS;
    return lim;
  endfunction

  // one cache access against the model; updates tags, data and age ranks
  function automatic cache_result_t cache_access(logic op,
                                                 logic [lct_pkg::ADDR_W-1:0] addr,
                                                 logic [lct_pkg::WORD_W-1:0] wdata);
    cache_result_t res;
    int slot;
    int victim;
    int old_rank;
    res = NO_RESULT;
    if (addr == '0) begin
      res.rejected = 1'b1;
      return res;
    end
    slot = -1;
    for (int i = 0; i < NUM_WAYS; i++)
      if (slot < 0 && tag_valid[i] && tag_addr[i] == addr) slot = i;

    // hit: lookup reads, insert overwrites; the entry becomes the newest
    if (slot >= 0) begin
      res.hit = 1'b1;
      if (op == lct_pkg::OP_LOOKUP) res.read_data = tag_data[slot];
      else tag_data[slot] = wdata;
      old_rank = age_rank[slot];
      for (int i = 0; i < NUM_WAYS; i++)
        if (tag_valid[i] && i != slot && age_rank[i] < old_rank) age_rank[i]++;
      age_rank[slot] = 0;
      return res;
    end
    if (op == lct_pkg::OP_LOOKUP) return res;

    // insert miss on a full table: drop the oldest entry
    if (fill_count >= cap_limit(cap_setting) && fill_count > 0) begin
      victim = -1;
      for (int i = 0; i < NUM_WAYS; i++)
        if (tag_valid[i] && (victim < 0 || age_rank[i] > age_rank[victim])) victim = i;
      if (victim >= 0) begin
        res.evicted         = 1'b1;
        res.evicted_address = tag_addr[victim];
        tag_valid[victim]   = 1'b0;
        age_rank[victim]    = 0;
        fill_count--;
      end
    end

    // new pair goes to the lowest free slot as the newest entry
    slot = -1;
    for (int i = 0; i < NUM_WAYS; i++)
      if (slot < 0 && !tag_valid[i]) slot = i;
    if (slot >= 0) begin
      for (int i = 0; i < NUM_WAYS; i++)
        if (tag_valid[i]) age_rank[i]++;
      tag_valid[slot] = 1'b1;
      tag_addr[slot]  = addr;
      tag_data[slot]  = wdata;
      age_rank[slot]  = 0;
      fill_count++;
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // present one item and hold it until accepted
  task automatic send_item(logic op, logic [lct_pkg::ADDR_W-1:0] addr,
                           logic [lct_pkg::WORD_W-1:0] wdata,
                           bit typed, cache_result_t typed_result);
    cache_result_t predicted;
    @(negedge clk);
    start      <= 1'b1;
    operation  <= op;
    address    <= addr;
    write_data <= wdata;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = cache_access(op, addr, wdata);
    pending_results.push_back(typed ? typed_result : predicted);
    items_sent++;
  endtask

  task automatic idle_gap(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // drain the table's pipeline, then an apb write of capacity_in_use
  task automatic write_capacity(logic [lct_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_REG_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    cap_setting = value[lct_pkg::CAP_REG_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result checker: every done strobe against the oldest expectation
  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result with no item waiting");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", 64'(want.hit), 64'(hit));
        check_field("read_data", want.read_data, read_data);
        check_field("evicted", 64'(want.evicted), 64'(evicted));
        check_field("evicted_address", want.evicted_address, evicted_address);
        check_field("rejected", 64'(want.rejected), 64'(rejected));
        if (want.hit) hit_count++;
        if (want.evicted) evict_count++;
        if (want.rejected) reject_count++;
      end
    end
  end

  initial begin
    logic [lct_pkg::PDATA_W-1:0] cap_value;
    logic [lct_pkg::ADDR_W-1:0]  addr_pool [$];
    logic [lct_pkg::ADDR_W-1:0]  addr;
    int                          pool_size;
    int                          pick;
    int                          waited;

    for (int i = 0; i < NUM_WAYS; i++) begin
      tag_valid[i] = 1'b0;
      tag_addr[i]  = '0;
      tag_data[i]  = '0;
      age_rank[i]  = 0;
    end
    fill_count  = 0;
    cap_setting = lct_pkg::CAP_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG)
        write_capacity(directed_rows[r].wdata[lct_pkg::PDATA_W-1:0]);
      else
        send_item(directed_rows[r].op, directed_rows[r].addr, directed_rows[r].wdata,
                  directed_rows[r].typed, directed_rows[r].result);
    end

    // random phases: a small address pool per phase so hits and evictions recur
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      cap_value = (phase == RAND_CAP_PHASE) ? lct_pkg::PDATA_W'($urandom)
                                            : phase_caps[phase];
      write_capacity(cap_value);
      pool_size = cap_limit(cap_value[lct_pkg::CAP_REG_W-1:0]) + $urandom_range(1, 8);
      addr_pool.delete();
      repeat (pool_size) addr_pool.push_back({$urandom, $urandom});
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (phase != RAND_PHASES - 1 && $urandom_range(0, 4) == 0)
          idle_gap($urandom_range(1, 8));
        pick = $urandom_range(0, 19);
        if (pick == 0) addr = '0;
        else if (pick == 1) addr = {$urandom, $urandom};
        else addr = addr_pool[$urandom_range(0, pool_size - 1)];
        send_item(1'($urandom_range(0, 1)), addr, {$urandom, $urandom}, 1'b0, NO_RESULT);
      end
    end

    // wind down: wait for the last results, then check that none is still missing
    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 50) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end

    $display("sent %0d items over %0d capacity settings incl. 0, 1, 2, 16 and 31",
             items_sent, RAND_PHASES + 3);
    $display("hits %0d, evictions %0d, zero-address refusals %0d, errors %0d",
             hit_count, evict_count, reject_count, error_count);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/lct_pkg.sv
src/lct_entry.sv
src/lru_cache_table_top.sv
bench/tb.sv
